// ----- hdl/tce_pkg.sv -----
`default_nettype none

package tce_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'd15;
    localparam logic [4:0] TOP_RESET    = 5'd5;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_BS   = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_ACTIVE = 3'd0,
        CFG_SPLIT  = 3'd1,
        CFG_ATTR0  = 3'd2,
        CFG_ATTR1  = 3'd3,
        CFG_TOP    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_PUT_WR,
        ST_CHK_SCR,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLK,
        ST_BS_RD,
        ST_BS_CHK,
        ST_BS_WR,
        ST_RD,
        ST_RD_WAIT,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/text_console_engine_core.sv -----
// One item is handled at a time. A scroll copies every cell of the rows below the fixed top
// rows up one row and then blanks the bottom row; a backspace that moves up a row scans that
// row from its right end for the last non-blank column.
// The next item is taken in the cycle after the result is loaded; an output stall holds the
// block in its final state until the result can be loaded.
// Reset is synchronous; then a clearing pass writes spaces to all 2*ROWS*COLUMNS entries.
`default_nettype none

module text_console_engine_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code, read_screen, read_row, read_col
    input  wire logic [1:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cell_index, cell_value, cursor_index, redraw_needed, read_char
    output logic [47:0]      m_tdata,
    output logic [0:0]       m_tuser,   // cell_write
    input  wire logic        cfg_wr_en,
    input  wire tce_pkg::cfg_idx_t cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);
    import tce_pkg::*;

    localparam int DEPTH = 2 * ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int HALF  = COLUMNS / 2;

    state_t state_reg, state_next;

    logic          cfg_active_reg;
    logic          cfg_split_reg;
    logic [7:0]    cfg_attr0_reg;
    logic [7:0]    cfg_attr1_reg;
    logic [4:0]    cfg_top_reg;

    logic [RW-1:0] row_reg [2];
    logic [RW-1:0] row_next [2];
    logic [CW-1:0] col_reg [2];
    logic [CW-1:0] col_next [2];
    logic [RW-1:0] scan_row_reg, scan_row_next;
    logic [CW-1:0] scan_col_reg, scan_col_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    op_t           op_reg, op_next;
    logic [7:0]    ch_reg, ch_next;
    logic          rs_reg, rs_next;
    logic [4:0]    rr_reg, rr_next;
    logic [6:0]    rc_reg, rc_next;

    logic          res_wr_reg, res_wr_next;
    logic [10:0]   res_idx_reg, res_idx_next;
    logic [15:0]   res_val_reg, res_val_next;
    logic          res_redraw_reg, res_redraw_next;
    logic [7:0]    res_rd_reg, res_rd_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [47:0]   m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;

    logic [7:0]    text_mem [DEPTH];
    logic [7:0]    mem_rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic          am_scr;
    logic [RW-1:0] am_row;
    logic [CW-1:0] am_col;

    logic          s;
    logic [CW-1:0] w_act;
    logic [7:0]    attr;
    logic [7:0]    top8;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic [10:0]   cur_pos;

    assign s       = cfg_active_reg;
    assign w_act   = cfg_split_reg ? CW'(HALF) : CW'(COLUMNS);
    assign attr    = s ? cfg_attr1_reg : cfg_attr0_reg;
    assign top8    = s ? 8'd0 : 8'(cfg_top_reg);
    assign cur_row = row_reg[s];
    assign cur_col = col_reg[s];
    assign cur_pos = 11'(32'(cur_row) * 32'(COLUMNS) + 32'(cur_col)
                         + ((cfg_split_reg && s) ? 32'(HALF) : 32'd0));

    assign mem_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg :
        AW'((32'(am_row) + (am_scr ? 32'(ROWS) : 32'd0)) * 32'(COLUMNS) + 32'(am_col));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            text_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= text_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_active_reg <= 1'b0;
            cfg_split_reg  <= 1'b0;
            cfg_attr0_reg  <= ATTR_RESET;
            cfg_attr1_reg  <= ATTR_RESET;
            cfg_top_reg    <= TOP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ACTIVE: cfg_active_reg <= cfg_wdata[0];
                CFG_SPLIT:  cfg_split_reg  <= cfg_wdata[0];
                CFG_ATTR0:  cfg_attr0_reg  <= cfg_wdata;
                CFG_ATTR1:  cfg_attr1_reg  <= cfg_wdata;
                CFG_TOP:    cfg_top_reg    <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            row_reg[0]   <= '0;
            row_reg[1]   <= '0;
            col_reg[0]   <= '0;
            col_reg[1]   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            row_reg[0]   <= row_next[0];
            row_reg[1]   <= row_next[1];
            col_reg[0]   <= col_next[0];
            col_reg[1]   <= col_next[1];
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_row_reg   <= scan_row_next;
        scan_col_reg   <= scan_col_next;
        op_reg         <= op_next;
        ch_reg         <= ch_next;
        rs_reg         <= rs_next;
        rr_reg         <= rr_next;
        rc_reg         <= rc_next;
        res_wr_reg     <= res_wr_next;
        res_idx_reg    <= res_idx_next;
        res_val_reg    <= res_val_next;
        res_redraw_reg <= res_redraw_next;
        res_rd_reg     <= res_rd_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_comb begin
        logic [CW-1:0] col_c;
        logic [RW-1:0] row_c;
        logic [CW-1:0] col_inc;
        logic [CW-1:0] scan_inc;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        row_next[0]     = row_reg[0];
        row_next[1]     = row_reg[1];
        col_next[0]     = col_reg[0];
        col_next[1]     = col_reg[1];
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        op_next         = op_reg;
        ch_next         = ch_reg;
        rs_next         = rs_reg;
        rr_next         = rr_reg;
        rc_next         = rc_reg;
        res_wr_next     = res_wr_reg;
        res_idx_next    = res_idx_reg;
        res_val_next    = res_val_reg;
        res_redraw_next = res_redraw_reg;
        res_rd_next     = res_rd_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = BLANK_CODE;
        am_scr          = s;
        am_row          = cur_row;
        am_col          = cur_col;

        col_c    = (cur_col >= w_act) ? w_act - CW'(1) : cur_col;
        row_c    = (32'(cur_row) >= 32'(ROWS)) ? RW'(ROWS - 1) : cur_row;
        col_inc  = cur_col + CW'(1);
        scan_inc = scan_col_reg + CW'(1);

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    ch_next    = s_tdata[7:0];
                    rs_next    = s_tdata[8];
                    rr_next    = s_tdata[13:9];
                    rc_next    = s_tdata[20:14];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                res_wr_next     = 1'b0;
                res_idx_next    = '0;
                res_val_next    = '0;
                res_redraw_next = 1'b0;
                res_rd_next     = '0;
                row_next[s]     = row_c;
                col_next[s]     = col_c;
                case (op_reg)
                    OP_PUT: begin
                        if (ch_reg == NEWLINE_CODE) begin
                            col_next[s] = '0;
                            row_next[s] = row_c + RW'(1);
                            state_next  = ST_CHK_SCR;
                        end else begin
                            state_next = ST_PUT_WR;
                        end
                    end
                    OP_BS: begin
                        state_next = ST_BS_WR;
                        if (col_c != '0) begin
                            col_next[s] = col_c - CW'(1);
                        end else if (8'(row_c) > top8) begin
                            row_next[s]   = row_c - RW'(1);
                            scan_col_next = w_act - CW'(1);
                            if (w_act != CW'(1)) begin
                                state_next = ST_BS_RD;
                            end
                        end
                    end
                    OP_READ: begin
                        state_next = ST_RD;
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_PUT_WR: begin
                mem_we       = 1'b1;
                mem_wdata    = ch_reg;
                res_wr_next  = 1'b1;
                res_idx_next = cur_pos;
                res_val_next = {attr, ch_reg};
                if (col_inc >= w_act) begin
                    col_next[s] = '0;
                    row_next[s] = cur_row + RW'(1);
                end else begin
                    col_next[s] = col_inc;
                end
                state_next = ST_CHK_SCR;
            end
            ST_CHK_SCR: begin
                state_next = ST_FIN;
                if (32'(cur_row) >= 32'(ROWS)) begin
                    res_redraw_next = 1'b1;
                    scan_col_next   = '0;
                    if (32'(top8) >= 32'(ROWS - 1)) begin
                        state_next = ST_BLK;
                    end else begin
                        scan_row_next = RW'(top8);
                        state_next    = ST_SCR_RD;
                    end
                end
            end
            ST_SCR_RD: begin
                am_row     = scan_row_reg + RW'(1);
                am_col     = scan_col_reg;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                am_row     = scan_row_reg;
                am_col     = scan_col_reg;
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata_reg;
                state_next = ST_SCR_RD;
                if (scan_inc == w_act) begin
                    scan_col_next = '0;
                    scan_row_next = scan_row_reg + RW'(1);
                    if (32'(scan_row_reg) + 32'd1 == 32'(ROWS - 1)) begin
                        state_next = ST_BLK;
                    end
                end else begin
                    scan_col_next = scan_inc;
                end
            end
            ST_BLK: begin
                am_row        = RW'(ROWS - 1);
                am_col        = scan_col_reg;
                mem_we        = 1'b1;
                scan_col_next = scan_inc;
                if (scan_inc == w_act) begin
                    row_next[s] = RW'(ROWS - 1);
                    col_next[s] = '0;
                    state_next  = ST_FIN;
                end
            end
            ST_BS_RD: begin
                am_col     = scan_col_reg;
                state_next = ST_BS_CHK;
            end
            ST_BS_CHK: begin
                if (mem_rdata_reg != BLANK_CODE) begin
                    col_next[s] = (scan_inc >= w_act) ? w_act - CW'(1) : scan_inc;
                    state_next  = ST_BS_WR;
                end else if (scan_col_reg == CW'(1)) begin
                    col_next[s] = '0;
                    state_next  = ST_BS_WR;
                end else begin
                    scan_col_next = scan_col_reg - CW'(1);
                    state_next    = ST_BS_RD;
                end
            end
            ST_BS_WR: begin
                mem_we       = 1'b1;
                res_wr_next  = 1'b1;
                res_idx_next = cur_pos;
                res_val_next = {attr, BLANK_CODE};
                state_next   = ST_FIN;
            end
            ST_RD: begin
                am_scr = rs_reg;
                am_row = RW'(rr_reg);
                am_col = CW'(rc_reg);
                if (32'(rr_reg) < 32'(ROWS) && 32'(rc_reg) < 32'(COLUMNS)) begin
                    state_next = ST_RD_WAIT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_RD_WAIT: begin
                res_rd_next = mem_rdata_reg;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_wr_reg;
                    m_tdata_next  = {1'b0, res_rd_reg, res_redraw_reg, cur_pos,
                                     res_val_reg, res_idx_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("Memory written while idle.");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[26:0] == 27'd0))
        else $error("Cell fields set on an item that wrote no cell.");

    a_put_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUT_WR) |-> (cur_col < w_act && 32'(cur_row) < 32'(ROWS)))
        else $error("Put cursor outside the active screen.");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> !$past(s_tready))
        else $error("Item accepted during the clearing pass.");
`endif

endmodule

`default_nettype wire

// ----- tb/text_console_engine_core_tb.sv -----
`default_nettype none

module text_console_engine_core_tb;
    import tce_pkg::*;

    localparam int COLS  = 80;
    localparam int NROWS = 25;
    localparam int LIMIT = 20000000;

    typedef struct {
        op_t        op;
        logic [7:0] ch;
        logic       rs;
        logic [4:0] rr;
        logic [6:0] rc;
    } key_item_t;

    typedef struct {
        logic        cw;
        logic [10:0] cidx;
        logic [15:0] cval;
        logic [10:0] cur;
        logic        rdw;
        logic [7:0]  rch;
    } console_out_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [47:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_wr_en = 0;
    cfg_idx_t cfg_addr = CFG_ACTIVE;
    logic [7:0] cfg_wdata = '0;

    text_console_engine_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    key_item_t    key_q[$];
    console_out_t screen_q[$];

    logic [7:0] txt[0:2*NROWS*COLS-1];
    int crow[2];
    int ccol[2];
    int act_scr, split_on, attr0, attr1, top_rows;

    int errors = 0;
    int results_seen = 0;
    int scrolls_seen = 0;
    int cycles = 0;
    int gap_left = 0;
    bit calm = 0;
    int hold_left = 0;
    bit hold_done = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("text_console_engine_core: mismatch");
            $finish;
        end
    end

    function automatic logic [10:0] disp_pos(int s, int r, int c);
        int p;
        p = r * COLS + c + (split_on ? s * (COLS / 2) : 0);
        return p[10:0];
    endfunction

    function automatic int first_row(int s);
        return s == 0 ? top_rows : 0;
    endfunction

    task automatic scroll_up(int s, int w);
        int r, c;
        for (r = first_row(s); r + 1 < NROWS; r++)
            for (c = 0; c < w; c++)
                txt[(s * NROWS + r) * COLS + c] = txt[(s * NROWS + r + 1) * COLS + c];
        for (c = 0; c < w; c++)
            txt[(s * NROWS + NROWS - 1) * COLS + c] = BLANK_CODE;
        crow[s] = NROWS - 1;
        ccol[s] = 0;
    endtask

    task automatic predict_console(input key_item_t it);
        int s, w, c;
        logic [7:0] attr;
        console_out_t e;
        s = act_scr;
        w = split_on ? COLS / 2 : COLS;
        attr = s ? attr1[7:0] : attr0[7:0];
        e = '{cw: 0, cidx: 0, cval: 0, cur: 0, rdw: 0, rch: 0};
        if (ccol[s] >= w) ccol[s] = w - 1;
        if (crow[s] >= NROWS) crow[s] = NROWS - 1;
        case (it.op)
            OP_PUT: begin
                if (it.ch == NEWLINE_CODE) begin
                    ccol[s] = 0;
                    crow[s]++;
                end else begin
                    txt[(s * NROWS + crow[s]) * COLS + ccol[s]] = it.ch;
                    e.cw = 1;
                    e.cidx = disp_pos(s, crow[s], ccol[s]);
                    e.cval = {attr, it.ch};
                    ccol[s]++;
                    if (ccol[s] >= w) begin
                        ccol[s] = 0;
                        crow[s]++;
                    end
                end
                if (crow[s] >= NROWS) begin
                    scroll_up(s, w);
                    e.rdw = 1;
                end
            end
            OP_BS: begin
                if (ccol[s] > 0) begin
                    ccol[s]--;
                end else if (crow[s] > first_row(s)) begin
                    crow[s]--;
                    for (c = w - 1; c > 0; c--) begin
                        if (txt[(s * NROWS + crow[s]) * COLS + c] != BLANK_CODE) begin
                            c++;
                            break;
                        end
                    end
                    if (c >= w) c = w - 1;
                    ccol[s] = c;
                end
                txt[(s * NROWS + crow[s]) * COLS + ccol[s]] = BLANK_CODE;
                e.cw = 1;
                e.cidx = disp_pos(s, crow[s], ccol[s]);
                e.cval = {attr, BLANK_CODE};
            end
            OP_READ: begin
                if (it.rr < NROWS && it.rc < COLS)
                    e.rch = txt[(it.rs * NROWS + it.rr) * COLS + it.rc];
            end
            default: ;
        endcase
        e.cur = disp_pos(s, crow[s], ccol[s]);
        screen_q.push_back(e);
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (calm) return 0;
        if (k < 60) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_console(key_q[0]);
                key_q.pop_front();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 0;
                end else if (key_q.size() > 0) begin
                    s_tvalid <= 1;
                    s_tdata <= {3'b000, key_q[0].rc, key_q[0].rr, key_q[0].rs, key_q[0].ch};
                    s_tuser <= key_q[0].op;
                    gap_left <= pick_gap();
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        console_out_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (screen_q.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    e = screen_q.pop_front();
                    if (e.rdw) scrolls_seen++;
                    if (m_tuser[0] !== e.cw) begin
                        $error("cell_write exp %0d got %0d", e.cw, m_tuser[0]); errors++;
                    end
                    if (m_tdata[10:0] !== e.cidx) begin
                        $error("cell_index exp %0d got %0d", e.cidx, m_tdata[10:0]); errors++;
                    end
                    if (m_tdata[26:11] !== e.cval) begin
                        $error("cell_value exp %h got %h", e.cval, m_tdata[26:11]); errors++;
                    end
                    if (m_tdata[37:27] !== e.cur) begin
                        $error("cursor_index exp %0d got %0d", e.cur, m_tdata[37:27]);
                        errors++;
                    end
                    if (m_tdata[38] !== e.rdw) begin
                        $error("redraw_needed exp %0d got %0d", e.rdw, m_tdata[38]); errors++;
                    end
                    if (m_tdata[46:39] !== e.rch) begin
                        $error("read_char exp %h got %h", e.rch, m_tdata[46:39]); errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 0;
            end else if (!hold_done && results_seen >= 200) begin
                hold_done <= 1;
                hold_left <= 400;
                m_tready <= 0;
            end else if (calm) begin
                m_tready <= 1;
            end else if ($urandom_range(0, 99) < 3) begin
                hold_left <= $urandom_range(10, 60);
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic cfg_write(cfg_idx_t idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val[7:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            CFG_ACTIVE: act_scr = val & 1;
            CFG_SPLIT:  split_on = val & 1;
            CFG_ATTR0:  attr0 = val & 8'hFF;
            CFG_ATTR1:  attr1 = val & 8'hFF;
            CFG_TOP:    top_rows = val & 5'h1F;
            default: ;
        endcase
    endtask

    task automatic push_key(op_t op, int ch, int rs, int rr, int rc);
        key_item_t it;
        it.op = op;
        it.ch = ch[7:0];
        it.rs = rs[0];
        it.rr = rr[4:0];
        it.rc = rc[6:0];
        key_q.push_back(it);
    endtask

    task automatic push_noise_key();
        push_key(op_t'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 1),
                 $urandom_range(0, 31), $urandom_range(0, 127));
    endtask

    task automatic wait_idle();
        wait (key_q.size() == 0 && !s_tvalid && screen_q.size() == 0);
        repeat (10) @(posedge aclk);
    endtask

    int n, k, i, total;
    initial begin
        for (i = 0; i < 2 * NROWS * COLS; i++) txt[i] = BLANK_CODE;
        crow = '{0, 0};
        ccol = '{0, 0};
        act_scr = 0; split_on = 0; attr0 = ATTR_RESET; attr1 = ATTR_RESET;
        top_rows = TOP_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        calm = 1;
        push_key(OP_BS, 0, 0, 0, 0);
        push_key(OP_PUT, 8'h00, 0, 0, 0);
        push_key(OP_PUT, 8'hFF, 1, 31, 127);
        push_key(OP_PUT, "A", 0, 0, 0);
        push_key(OP_PUT, NEWLINE_CODE, 0, 0, 0);
        push_key(OP_BS, 0, 0, 0, 0);
        push_key(OP_BS, 0, 0, 0, 0);
        push_key(OP_READ, 0, 0, 0, 1);
        push_key(OP_READ, 0, 1, 24, 79);
        push_key(OP_READ, 0, 0, 25, 0);
        push_key(OP_READ, 0, 1, 31, 127);
        push_key(OP_READ, 0, 0, 0, 80);
        push_key(OP_NONE, 8'hFF, 1, 31, 127);
        for (i = 0; i < 8; i++) push_key(OP_PUT, NEWLINE_CODE, 0, 0, 0);
        for (i = 0; i < 60; i++) push_key(OP_PUT, "a" + i % 26, 0, 0, 0);
        wait_idle();
        cfg_write(CFG_SPLIT, 1);
        push_key(OP_PUT, "Z", 0, 0, 0);
        push_key(OP_BS, 0, 0, 0, 0);
        wait_idle();

        total = 0;
        for (n = 0; total < 670; n++) begin
            wait_idle();
            calm = (n % 5 == 3);
            cfg_write(CFG_ACTIVE, n % 2);
            cfg_write(CFG_SPLIT, (n / 2) % 2);
            cfg_write(CFG_ATTR0, (n % 4 == 0) ? 0 : (n % 4 == 1) ? 255 : $urandom_range(0, 255));
            cfg_write(CFG_ATTR1, (n % 4 == 1) ? 0 : (n % 4 == 2) ? 255 : $urandom_range(0, 255));
            cfg_write(CFG_TOP, (n % 3 == 0) ? 0 : (n % 3 == 1) ? 24 : $urandom_range(0, 24));
            for (i = 0; i < 60; ) begin
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    repeat ($urandom_range(1, split_on ? 45 : 85)) begin
                        push_key(OP_PUT, $urandom_range(0, 1) ? $urandom_range(33, 126)
                                         : $urandom_range(0, 255), 0, 0, 0);
                        i++;
                    end
                    if ($urandom_range(0, 1)) begin push_key(OP_PUT, NEWLINE_CODE, 0, 0, 0); i++; end
                end else if (k < 6) begin
                    repeat ($urandom_range(3, 26)) begin
                        push_key(OP_PUT, NEWLINE_CODE, 0, 0, 0); i++;
                    end
                end else if (k < 8) begin
                    repeat ($urandom_range(1, 6)) begin push_key(OP_BS, 0, 0, 0, 0); i++; end
                end else if (k < 9) begin
                    push_key(OP_READ, 0, $urandom_range(0, 1), $urandom_range(0, 24),
                             $urandom_range(0, 79));
                    i++;
                end else begin
                    push_noise_key(); i++;
                end
            end
            total += i;
        end
        wait_idle();
        repeat (50) @(posedge aclk);
        $display("Ran %0d phases, %0d results checked, %0d with a scroll.",
                 n, results_seen, scrolls_seen);
        if (errors == 0 && screen_q.size() == 0) begin
            $display("text_console_engine_core: match");
        end else begin
            $display("text_console_engine_core: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
